/* design/assert_macros.svh */
// Assertion macros shared by the descriptor scan RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/upds_pkg.sv */
// Types and constants for the USB printer descriptor scan.
package upds_pkg;

	// Configuration register indexes
	typedef enum logic {
		REG_TARGET_CLASS    = 1'b0,
		REG_TARGET_SUBCLASS = 1'b1
	} cfg_reg_t;

	localparam logic [7:0] CLASS_RESET    = 8'h07;
	localparam logic [7:0] SUBCLASS_RESET = 8'h01;

	// Descriptor types
	localparam logic [7:0] DESC_TYPE_IFACE = 8'h04;
	localparam logic [7:0] DESC_TYPE_EP    = 8'h05;

	// Minimum lengths for a descriptor to be examined
	localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
	localparam logic [7:0] EP_MIN_LEN    = 8'd7;

	// Byte offsets inside a sub-descriptor
	localparam int OFF_LEN      = 0;
	localparam int OFF_TYPE     = 1;
	localparam int OFF_FIELD_A  = 2;
	localparam int OFF_EP_ATTR  = 3;
	localparam int OFF_IF_CLASS = 5;
	localparam int OFF_IF_SUB   = 6;

	// Absolute byte positions in the configuration descriptor
	localparam int POS_LEN_LO  = 2;
	localparam int POS_LEN_HI  = 3;
	localparam int POS_BODY    = 4;
	localparam int POS_CFG_VAL = 5;

	// Endpoint attribute decode
	localparam logic [1:0] XFER_BULK = 2'b10;

	// One input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} byte_item_t;

	// Result of a finished transfer
	typedef struct packed {
		logic       found;
		logic [3:0] endpoint_number;
		logic [7:0] cfg_val;
	} scan_res_t;

endpackage

/* design/usb_byte_if.sv */
// Valid/ready channel carrying descriptor bytes.
interface usb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

/* design/usb_result_if.sv */
// Valid/ready channel carrying scan results.
interface usb_result_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [3:0] endpoint_number;
	logic [7:0] cfg_val;

	modport source (output valid, output found, output endpoint_number,
		output cfg_val, input ready);
	modport sink   (input valid, input found, input endpoint_number,
		input cfg_val, output ready);
endinterface

/* design/usb_printer_descriptor_scan.sv */
// Top level of the USB printer descriptor scan.
//
// Usage:
//   byte_in carries a configuration descriptor, one byte per item, with
//   last set on the final byte of the transfer. result_out carries one item
//   per transfer: found, the endpoint number of the first bulk OUT endpoint
//   inside an interface of the target class and subclass, and the
//   configuration value (byte 5).
//   cfg_we / cfg_index / cfg_wdata write target_class (index 0) and
//   target_subclass (index 1); write them only while no transfer is open.
// Timing:
//   Each byte is processed in the cycle it is accepted; one byte per cycle
//   is taken back to back while byte_in.ready is high. The result appears on
//   result_out the cycle after the last byte is accepted. The scan state clears
//   on that byte, so the next transfer may start in the following cycle.
//   The result register is the only buffer: byte_in.ready drops only while
//   a result waits and result_out.ready is low.
// Reset:
//   arst_n clears the scan and restores the targets to class 7, subclass 1.
`include "assert_macros.svh"

module usb_printer_descriptor_scan #(
	parameter int MAX_DESC_BYTES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_wdata,
	usb_byte_if.sink            byte_in,
	usb_result_if.source        result_out
);

	logic [7:0]           tclass_q, tsub_q;
	logic                 out_valid_q;
	upds_pkg::scan_res_t  res_q;
	upds_pkg::scan_res_t  res;
	upds_pkg::byte_item_t item;
	logic                 in_ready, take;

	assign in_ready      = !out_valid_q || result_out.ready;
	assign byte_in.ready = in_ready;
	assign take          = byte_in.valid && in_ready;
	assign item.data_byte = byte_in.data_byte;
	assign item.last      = byte_in.last;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tclass_q <= upds_pkg::CLASS_RESET;
			tsub_q   <= upds_pkg::SUBCLASS_RESET;
		end else if (cfg_we) begin
			unique case (upds_pkg::cfg_reg_t'(cfg_index))
				upds_pkg::REG_TARGET_CLASS:    tclass_q <= cfg_wdata;
				upds_pkg::REG_TARGET_SUBCLASS: tsub_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	upds_scan #(
		.MAX_DESC_BYTES (MAX_DESC_BYTES)
	) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.item            (item),
		.target_class    (tclass_q),
		.target_subclass (tsub_q),
		.res             (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && byte_in.last) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && byte_in.last) begin
			res_q <= res;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.found           = res_q.found;
	assign result_out.endpoint_number = res_q.endpoint_number;
	assign result_out.cfg_val         = res_q.cfg_val;

	// A last byte always leaves a result waiting
	`ASSERT_NEXT(a_last_loads, clk, arst_n, take && byte_in.last, out_valid_q)
	// No endpoint number is reported without a find
	`ASSERT_IMPLIES(a_ep_zero, clk, arst_n, out_valid_q && !res_q.found, res_q.endpoint_number == 4'h0)

endmodule

/* design/upds_scan.sv */
// Per-byte descriptor walker: holds the scan state and updates it on each item.
`include "assert_macros.svh"

module upds_scan #(
	parameter int MAX_DESC_BYTES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  upds_pkg::byte_item_t  item,
	input  logic [7:0]            target_class,
	input  logic [7:0]            target_subclass,
	output upds_pkg::scan_res_t   res
);

	localparam int PW = $clog2(MAX_DESC_BYTES + 1);
	localparam int WW = PW + 4;
	// Width holding both an offset and a length byte, plus one
	localparam int CW = ((PW > 8) ? PW : 8) + 1;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_DESC_BYTES);

	logic [PW-1:0] pos_q, start_q, tot_q;
	logic [7:0]    dlen_q, lenlo_q, dtype_q, fa_q, cfgv_q;
	logic          match_q, stop_q;
	logic [4:0]    fep_q;

	logic [PW-1:0] pos_d, start_d, tot_d;
	logic [7:0]    dlen_d, lenlo_d, dtype_d, fa_d, cfgv_d;
	logic          match_d, stop_d;
	logic [4:0]    fep_d;

	logic [PW-1:0] pos_u, start_u, tot_u;
	logic [7:0]    dlen_u, lenlo_u, dtype_u, fa_u, cfgv_u;
	logic          match_u, stop_u;
	logic [4:0]    fep_u;

	logic          active;
	logic [15:0]   tot_raw;
	logic [PW-1:0] tot_new;
	logic [7:0]    v;
	logic [PW-1:0] off;
	logic [WW-1:0] start_w, tot_w;
	logic          ep_ok, iface_ok;

	// Length capture and clamp, byte masking past the total length, and endpoint/interface checks
	always_comb begin
		active  = pos_q < MAX_POS;
		tot_raw = {item.data_byte, lenlo_q};
		if (pos_q == PW'(upds_pkg::POS_LEN_HI)) begin
			tot_new = (tot_raw > 16'(MAX_DESC_BYTES)) ? MAX_POS : PW'(tot_raw);
		end else begin
			tot_new = tot_q;
		end
		if (pos_q >= PW'(upds_pkg::POS_BODY) && pos_q >= tot_q) begin
			v = 8'h00;
		end else begin
			v = item.data_byte;
		end
		off     = pos_q - start_q;
		start_w = WW'(start_q);
		tot_w   = WW'(tot_new);
		ep_ok   = dtype_q == upds_pkg::DESC_TYPE_EP && dlen_q >= upds_pkg::EP_MIN_LEN
			&& start_w + WW'(upds_pkg::EP_MIN_LEN) <= tot_w && match_q
			&& v[1:0] == upds_pkg::XFER_BULK && !fa_q[7];
		iface_ok = dtype_q == upds_pkg::DESC_TYPE_IFACE
			&& dlen_q >= upds_pkg::IFACE_MIN_LEN
			&& start_w + WW'(upds_pkg::IFACE_MIN_LEN) <= tot_w;
	end

	// Walk the sub-descriptors
	always_comb begin
		logic halt;
		halt    = 1'b0;
		pos_u   = pos_q;
		start_u = start_q;
		tot_u   = tot_q;
		dlen_u  = dlen_q;
		lenlo_u = lenlo_q;
		dtype_u = dtype_q;
		fa_u    = fa_q;
		cfgv_u  = cfgv_q;
		match_u = match_q;
		stop_u  = stop_q;
		fep_u   = fep_q;
		if (active) begin
			pos_u = pos_q + PW'(1);
			tot_u = tot_new;
			if (pos_q == PW'(upds_pkg::POS_LEN_LO)) begin
				lenlo_u = item.data_byte;
			end
			if (pos_q == PW'(upds_pkg::POS_CFG_VAL)) begin
				cfgv_u = v;
			end
			if (!stop_q && pos_q >= start_q) begin
				if (pos_q >= PW'(upds_pkg::POS_LEN_HI)
					&& start_w + WW'(2) > tot_w) begin
					stop_u = 1'b1;
				end else begin
					unique case (off)
						PW'(upds_pkg::OFF_LEN): begin
							dlen_u = v;
							if (v == 8'h00) begin
								stop_u = 1'b1;
								halt   = 1'b1;
							end
						end
						PW'(upds_pkg::OFF_TYPE):    dtype_u = v;
						PW'(upds_pkg::OFF_FIELD_A): fa_u = v;
						PW'(upds_pkg::OFF_EP_ATTR): begin
							if (ep_ok) begin
								fep_u  = {1'b1, fa_q[3:0]};
								stop_u = 1'b1;
								halt   = 1'b1;
							end
						end
						PW'(upds_pkg::OFF_IF_CLASS): fa_u = v;
						PW'(upds_pkg::OFF_IF_SUB): begin
							if (iface_ok) begin
								match_u = (fa_q == target_class) && (v == target_subclass);
							end
						end
						default: ;
					endcase
					// Descriptor ends on this byte: next one starts right after it
					if (!halt && (CW'(off) + CW'(1)) == CW'(dlen_u)) begin
						start_u = pos_q + PW'(1);
					end
				end
			end
		end
	end

	// Result and next state: a last item reports, then clears the scan
	always_comb begin
		res.found           = fep_u[4];
		res.endpoint_number = fep_u[3:0];
		res.cfg_val         = cfgv_u;
		pos_d   = pos_q;
		start_d = start_q;
		tot_d   = tot_q;
		dlen_d  = dlen_q;
		lenlo_d = lenlo_q;
		dtype_d = dtype_q;
		fa_d    = fa_q;
		cfgv_d  = cfgv_q;
		match_d = match_q;
		stop_d  = stop_q;
		fep_d   = fep_q;
		if (take) begin
			if (item.last) begin
				pos_d   = '0;
				start_d = '0;
				tot_d   = '0;
				dlen_d  = '0;
				lenlo_d = '0;
				dtype_d = '0;
				fa_d    = '0;
				cfgv_d  = '0;
				match_d = 1'b0;
				stop_d  = 1'b0;
				fep_d   = '0;
			end else begin
				pos_d   = pos_u;
				start_d = start_u;
				tot_d   = tot_u;
				dlen_d  = dlen_u;
				lenlo_d = lenlo_u;
				dtype_d = dtype_u;
				fa_d    = fa_u;
				cfgv_d  = cfgv_u;
				match_d = match_u;
				stop_d  = stop_u;
				fep_d   = fep_u;
			end
		end
	end

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			tot_q   <= '0;
			dlen_q  <= '0;
			lenlo_q <= '0;
			dtype_q <= '0;
			fa_q    <= '0;
			cfgv_q  <= '0;
			match_q <= 1'b0;
			stop_q  <= 1'b0;
			fep_q   <= '0;
		end else begin
			pos_q   <= pos_d;
			start_q <= start_d;
			tot_q   <= tot_d;
			dlen_q  <= dlen_d;
			lenlo_q <= lenlo_d;
			dtype_q <= dtype_d;
			fa_q    <= fa_d;
			cfgv_q  <= cfgv_d;
			match_q <= match_d;
			stop_q  <= stop_d;
			fep_q   <= fep_d;
		end
	end

	// A captured endpoint always ends the walk
	`ASSERT_IMPLIES(a_found_stops, clk, arst_n, fep_q[4], stop_q)
	// The walk never points past the byte about to arrive
	`ASSERT_IMPLIES(a_start_bounded, clk, arst_n, 1'b1, start_q <= pos_q)

endmodule

/* sim/usb_printer_descriptor_scan_test.sv */
// Self-checking testbench for the USB printer descriptor scan block.
module usb_printer_descriptor_scan_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DESC_BYTES = 256;
	localparam int ITEM_TARGET    = 1000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int STALL_LIMIT    = 2000;
	localparam int MAX_REPORTS    = 10;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;

	usb_byte_if   byte_in ();
	usb_result_if result_out ();

	usb_printer_descriptor_scan #(
		.MAX_DESC_BYTES(MAX_DESC_BYTES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_in),
		.result_out(result_out)
	);

	// Predicted scan results, oldest first
	upds_pkg::scan_res_t  pending_scans [$];
	upds_pkg::byte_item_t xfer [$];

	int items_sent     = 0;
	int transfers_done = 0;
	int mismatches     = 0;
	int idle_cycles    = 0;
	bit idle_enable    = 1'b1;

	// Predictor state
	logic [7:0] tgt_class;
	logic [7:0] tgt_subclass;
	logic [8:0] sc_pos;
	logic [9:0] sc_start;
	logic [7:0] sc_len;
	logic [8:0] sc_total;
	logic [7:0] sc_len_lo;
	logic [7:0] sc_type;
	logic [7:0] sc_field;
	logic       sc_in_match;
	logic [7:0] sc_cfg;
	logic [4:0] sc_ep;
	logic       sc_stop;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function void clear_scan_state();
		sc_pos      = '0;
		sc_start    = '0;
		sc_len      = '0;
		sc_total    = '0;
		sc_len_lo   = '0;
		sc_type     = '0;
		sc_field    = '0;
		sc_in_match = 1'b0;
		sc_cfg      = '0;
		sc_ep       = '0;
		sc_stop     = 1'b0;
	endfunction

	// Sub-descriptor walk for one byte at absolute position p
	function void walk_descriptor(input int p, input logic [7:0] v);
		int off;
		if (sc_stop || p < sc_start)
			return;
		// descriptor header would not fit inside the total length
		if (p >= upds_pkg::POS_LEN_HI && sc_start + 2 > sc_total) begin
			sc_stop = 1'b1;
			return;
		end
		off = p - sc_start;
		case (off)
			upds_pkg::OFF_LEN: begin
				sc_len = v;
				if (v == 8'd0) begin
					sc_stop = 1'b1;
					return;
				end
			end
			upds_pkg::OFF_TYPE: sc_type = v;
			upds_pkg::OFF_FIELD_A: sc_field = v;
			upds_pkg::OFF_EP_ATTR: begin
				// first bulk OUT endpoint inside a matching interface
				if (sc_type == upds_pkg::DESC_TYPE_EP && sc_len >= upds_pkg::EP_MIN_LEN &&
						sc_start + upds_pkg::EP_MIN_LEN <= sc_total && sc_in_match &&
						v[1:0] == upds_pkg::XFER_BULK && !sc_field[7]) begin
					sc_ep   = {1'b1, sc_field[3:0]};
					sc_stop = 1'b1;
					return;
				end
			end
			upds_pkg::OFF_IF_CLASS: sc_field = v;
			upds_pkg::OFF_IF_SUB: begin
				if (sc_type == upds_pkg::DESC_TYPE_IFACE &&
						sc_len >= upds_pkg::IFACE_MIN_LEN &&
						sc_start + upds_pkg::IFACE_MIN_LEN <= sc_total)
					sc_in_match = (sc_field == tgt_class) && (v == tgt_subclass);
			end
			default: ;
		endcase
		if (off + 1 == sc_len)
			sc_start = sc_start + sc_len;
	endfunction

	// Advance the predictor by one byte; returns 1 when a result is due
	function bit scan_byte(input logic [7:0] b, input logic l,
			output upds_pkg::scan_res_t res);
		int         p;
		int         full_len;
		logic [7:0] v;
		p   = sc_pos;
		v   = b;
		res = '0;
		if (p < MAX_DESC_BYTES) begin
			if (p == upds_pkg::POS_LEN_LO)
				sc_len_lo = b;
			if (p == upds_pkg::POS_LEN_HI) begin
				full_len = {b, sc_len_lo};
				sc_total = 9'((full_len > MAX_DESC_BYTES) ? MAX_DESC_BYTES : full_len);
			end
			// body bytes past the total length read as zero
			if (p >= upds_pkg::POS_BODY && p >= sc_total)
				v = 8'd0;
			if (p == upds_pkg::POS_CFG_VAL)
				sc_cfg = v;
			walk_descriptor(p, v);
			sc_pos = 9'(p + 1);
		end
		if (!l)
			return 1'b0;
		res.found           = sc_ep[4];
		res.endpoint_number = sc_ep[3:0];
		res.cfg_val         = sc_cfg;
		clear_scan_state();
		return 1'b1;
	endfunction

	// Result checker
	always @(posedge clk) begin : check_results
		upds_pkg::scan_res_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			if (pending_scans.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: found=%0d ep=%0d cfg=0x%02h",
						result_out.found, result_out.endpoint_number,
						result_out.cfg_val);
			end else begin
				want = pending_scans.pop_front();
				if (result_out.found !== want.found ||
						result_out.endpoint_number !== want.endpoint_number ||
						result_out.cfg_val !== want.cfg_val) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result mismatch: expected %0d/%0d/0x%02h, got %0d/%0d/0x%02h",
							want.found, want.endpoint_number, want.cfg_val,
							result_out.found, result_out.endpoint_number,
							result_out.cfg_val);
				end
			end
		end
	end

	// Watchdog: cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((byte_in.valid && byte_in.ready) || (result_out.valid && result_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("usb_printer_descriptor_scan_test: FAIL");
		$finish;
	end

	// Result-side back-pressure in random bursts
	initial begin : drive_result_ready
		result_out.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (idle_enable && $urandom_range(0, 1) == 0) begin
				result_out.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			result_out.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic l = 1'b0);
		xfer.push_back({b, l});
	endtask

	// Drive one item; valid stays high until the next item or a drain
	task automatic send_byte(input upds_pkg::byte_item_t it);
		upds_pkg::scan_res_t res;
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			byte_in.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		byte_in.valid     <= 1'b1;
		byte_in.data_byte <= it.data_byte;
		byte_in.last      <= it.last;
		@(posedge clk);
		while (!byte_in.ready)
			@(posedge clk);
		if (scan_byte(it.data_byte, it.last, res))
			pending_scans.push_back(res);
		items_sent++;
	endtask

	task automatic send_transfer();
		for (int i = 0; i < xfer.size(); i++)
			send_byte(xfer[i]);
		transfers_done++;
	endtask

	task automatic wait_drained();
		byte_in.valid <= 1'b0;
		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write, only with no transfer open
	task automatic write_target(input upds_pkg::cfg_reg_t idx, input logic [7:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == upds_pkg::REG_TARGET_CLASS)
			tgt_class = val;
		else
			tgt_subclass = val;
	endtask

	task automatic set_targets(input logic [7:0] cls, input logic [7:0] sub);
		write_target(upds_pkg::REG_TARGET_CLASS, cls);
		write_target(upds_pkg::REG_TARGET_SUBCLASS, sub);
	endtask

	// Random descriptor: mostly well formed, some noise and broken ones
	task automatic build_random_transfer(input bit long_one);
		int         n_sub;
		int         kind;
		int         len;
		int         size;
		int         tot;
		int         cut;
		logic [7:0] body [16];
		xfer.delete();
		if (!long_one && $urandom_range(0, 9) == 0) begin
			// noise: raw bytes, stray last marks
			repeat ($urandom_range(1, 40))
				push_byte(8'($urandom), $urandom_range(0, 7) == 0);
		end else begin
			// header, total length patched in below
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : 9;
			push_byte(len[7:0]);
			push_byte(8'h02);
			push_byte(8'h00);
			push_byte(8'h00);
			repeat (5) push_byte(8'($urandom));
			n_sub = long_one ? 2 : $urandom_range(0, 6);
			repeat (n_sub) begin
				foreach (body[i])
					body[i] = 8'($urandom);
				kind = $urandom_range(0, 9);
				if (kind <= 2) begin
					// interface, usually of the target class
					if ($urandom_range(0, 9) == 0)
						len = $urandom_range(1, 8);
					else if ($urandom_range(0, 9) == 0)
						len = $urandom_range(10, 15);
					else
						len = 9;
					body[1] = upds_pkg::DESC_TYPE_IFACE;
					if ($urandom_range(0, 4) != 0)
						body[5] = tgt_class;
					if ($urandom_range(0, 4) != 0)
						body[6] = tgt_subclass;
				end else if (kind <= 6) begin
					// endpoint, mostly bulk OUT
					if ($urandom_range(0, 9) == 0)
						len = $urandom_range(1, 6);
					else if ($urandom_range(0, 9) == 0)
						len = $urandom_range(8, 10);
					else
						len = 7;
					body[1]    = upds_pkg::DESC_TYPE_EP;
					body[2][7] = ($urandom_range(0, 3) == 0);
					if ($urandom_range(0, 3) != 0)
						body[3][1:0] = upds_pkg::XFER_BULK;
				end else if (kind <= 8) begin
					len = $urandom_range(2, 15);
				end else begin
					// zero length byte ends the walk
					len = $urandom_range(1, 4);
				end
				body[0] = (kind == 9) ? 8'd0 : len[7:0];
				for (int i = 0; i < len; i++)
					push_byte(body[i]);
			end
			// long descriptor past the buffer size
			if (long_one) begin
				while (xfer.size() < 300) begin
					len = $urandom_range(100, 255);
					push_byte(len[7:0]);
					repeat (len - 1) push_byte(8'($urandom));
				end
			end
			size = xfer.size();
			case ($urandom_range(0, 19))
				0, 1:    tot = $urandom_range(0, size);
				2, 3:    tot = size + $urandom_range(1, 20);
				4:       tot = $urandom_range(0, 16'hFFFF);
				5:       tot = 0;
				default: tot = size;
			endcase
			if (long_one)
				tot = 16'hFFFF;
			xfer[upds_pkg::POS_LEN_LO].data_byte = tot[7:0];
			xfer[upds_pkg::POS_LEN_HI].data_byte = tot[15:8];
			// early last or trailing bytes
			case ($urandom_range(0, 9))
				0: begin
					cut  = $urandom_range(1, size);
					xfer = xfer[0:cut-1];
				end
				1: repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
				default: ;
			endcase
		end
		xfer[$].last = 1'b1;
	endtask

	// Printer interface with a bulk OUT endpoint, reset targets
	task automatic test_bulk_out_default();
		xfer.delete();
		push_byte(8'd6); push_byte(8'h02); push_byte(8'd22); push_byte(8'h00);
		push_byte(8'h01); push_byte(8'hFF);
		push_byte(8'd9); push_byte(upds_pkg::DESC_TYPE_IFACE);
		push_byte(8'h00); push_byte(8'h00);
		push_byte(8'h01); push_byte(upds_pkg::CLASS_RESET);
		push_byte(upds_pkg::SUBCLASS_RESET);
		push_byte(8'h02); push_byte(8'h00);
		push_byte(8'd7); push_byte(upds_pkg::DESC_TYPE_EP);
		push_byte(8'h0F); push_byte(8'h02);
		push_byte(8'h40); push_byte(8'h00); push_byte(8'h00, 1'b1);
		send_transfer();
	endtask

	// Zero total length: config value reads as zero
	task automatic test_zero_total();
		xfer.delete();
		push_byte(8'd9); push_byte(8'h02); push_byte(8'h00); push_byte(8'h00);
		push_byte(8'h01); push_byte(8'hAA, 1'b1);
		send_transfer();
	endtask

	// Last on the very first byte
	task automatic test_early_last();
		xfer.delete();
		push_byte(8'hFF, 1'b1);
		send_transfer();
	endtask

	// Random descriptors over several target settings
	task automatic test_random_descriptors();
		int phase;
		int count;
		phase = 0;
		count = 0;
		while (items_sent < ITEM_TARGET) begin
			if (count % 8 == 0) begin
				case (phase % 4)
					0:       set_targets(8'h00, 8'h00);
					1:       set_targets(8'hFF, 8'hFF);
					2:       set_targets(8'($urandom), 8'($urandom));
					default: set_targets(upds_pkg::CLASS_RESET, upds_pkg::SUBCLASS_RESET);
				endcase
				phase++;
			end
			// no idling in the closing stretch
			if (items_sent >= ITEM_TARGET * 85 / 100)
				idle_enable = 1'b0;
			build_random_transfer(count == 3);
			send_transfer();
			count++;
		end
	endtask

	initial begin : run_tests
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = upds_pkg::REG_TARGET_CLASS;
		cfg_wdata         = 8'h00;
		byte_in.valid     = 1'b0;
		byte_in.data_byte = 8'h00;
		byte_in.last      = 1'b0;
		tgt_class         = upds_pkg::CLASS_RESET;
		tgt_subclass      = upds_pkg::SUBCLASS_RESET;
		clear_scan_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bulk_out_default();
		test_zero_total();
		test_early_last();
		test_random_descriptors();

		wait_drained();
		if (mismatches == 0 && pending_scans.size() == 0)
			$display("usb_printer_descriptor_scan_test: PASS");
		else
			$display("usb_printer_descriptor_scan_test: FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/upds_pkg.sv
design/usb_byte_if.sv
design/usb_result_if.sv
design/upds_scan.sv
design/usb_printer_descriptor_scan.sv
sim/usb_printer_descriptor_scan_test.sv
